// ===== hdl/alm_pkg.sv =====
// Shared constants, payload structs and control structs for the audio level meter.
`default_nettype none

package alm_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned COUNT_BITS  = 16;

  // The item count saturates at 2^COUNT_BITS, so it needs one extra bit.
  localparam int unsigned CNT_W   = COUNT_BITS + 1;
  localparam int unsigned SUM_W   = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned SQ_FULL = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
  // The sum of squares wraps modulo 2^64 when the exact width would exceed it.
  localparam int unsigned SQ_W    = (SQ_FULL > 64) ? 64 : SQ_FULL;
  localparam int unsigned DIV_W   = SQ_W;
  localparam int unsigned SQRT_W  = DIV_W + (DIV_W % 2);
  localparam int unsigned ROOT_W  = SQRT_W / 2;
  localparam int unsigned STEP_W  = $clog2(DIV_W);

  localparam logic [CNT_W-1:0] COUNT_MAX = {1'b1, {COUNT_BITS{1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          non_finite;
    logic                          last_sample;
  } alm_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]        peak_level;
    logic signed [SAMPLE_BITS-1:0] dc_offset;
    logic [SAMPLE_BITS-1:0]        rms_level;
    logic                          saw_non_finite;
    logic [CNT_W-1:0]              sample_total;
    logic                          too_long;
  } alm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic ld_sum;
    logic div_step;
    logic ld_sq;
    logic ld_root;
    logic root_step;
    logic finish;
  } alm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_taken;
    logic pipe_idle;
    logic skip_math;
    logic out_free;
  } alm_status_t;

endpackage

`default_nettype wire

// ===== hdl/audio_level_meter_core.sv =====
// Top level of the audio level meter: peak, DC offset and RMS over one buffer.
//
//   Port group    Direction  Handshake              Payload
//   in_*          request in in_valid_i/in_stall_o   alm_in_t  (sample, flags)
//   out_*         result out out_valid_o/out_stall_i alm_out_t (levels, count, flags)
//
// Samples are taken one per cycle while a buffer accumulates.
// After the last sample the input stalls while the pipeline drains and then the shared
// restoring divider (one quotient bit a cycle, run for the mean and for the mean square)
// and the root unit do their work.
// A buffer with a non-finite or overflow flag skips the math and goes from the drain to the result load.
// Reset clears all accumulators; a waiting result does not block the next buffer
// until that buffer's own result is ready to load.
`default_nettype none

module audio_level_meter_core import alm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  alm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output alm_out_t out_data_o
);

  alm_cmd_t    cmd;
  alm_status_t status;

  alm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  alm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !cmd.take;

endmodule

`default_nettype wire

// ===== hdl/alm_ctrl.sv =====
// Sequencing controller: accumulation, drain, divisions, square root and result load.
`default_nettype none

module alm_ctrl import alm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  alm_status_t status_i,
  output alm_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_LD_SUM,
    ST_DIV_SUM,
    ST_LD_SQ,
    ST_DIV_SQ,
    ST_LD_ROOT,
    ST_ROOT,
    ST_FINISH
  } state_e;

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = '0;
    case (state_q)
      ST_ACCUM: begin
        if (status_i.last_taken) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status_i.pipe_idle) begin
          state_d = status_i.skip_math ? ST_FINISH : ST_LD_SUM;
        end
      end
      ST_LD_SUM: state_d = ST_DIV_SUM;
      ST_DIV_SUM: begin
        if (step_q == DIV_LAST) begin
          state_d = ST_LD_SQ;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_LD_SQ: state_d = ST_DIV_SQ;
      ST_DIV_SQ: begin
        if (step_q == DIV_LAST) begin
          state_d = ST_LD_ROOT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_LD_ROOT: state_d = ST_ROOT;
      ST_ROOT: begin
        if (step_q == ROOT_LAST) begin
          state_d = ST_FINISH;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_ACCUM;
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.take      = (state_q == ST_ACCUM);
    cmd_o.ld_sum    = (state_q == ST_LD_SUM);
    cmd_o.div_step  = (state_q == ST_DIV_SUM) || (state_q == ST_DIV_SQ);
    cmd_o.ld_sq     = (state_q == ST_LD_SQ);
    cmd_o.ld_root   = (state_q == ST_LD_ROOT);
    cmd_o.root_step = (state_q == ST_ROOT);
    cmd_o.finish    = (state_q == ST_FINISH) && status_i.out_free;
  end

endmodule

`default_nettype wire

// ===== hdl/alm_datapath.sv =====
// Accumulation pipeline, shared restoring divider, square root unit and result register.
`default_nettype none

module alm_datapath import alm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  alm_cmd_t    cmd_i,
  output alm_status_t status_o,
  input  logic        in_valid_i,
  input  alm_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output alm_out_t    out_data_o
);

  logic accept;
  assign accept = in_valid_i && cmd_i.take;

  // Count and flags are settled at accept time, so beside the sample the pipeline only carries enables.
  logic [CNT_W-1:0] count_q, count_d;
  logic             bad_q, bad_d;
  logic             over_q, over_d;

  always_comb begin
    count_d = count_q;
    bad_d   = bad_q;
    over_d  = over_q;
    if (cmd_i.finish) begin
      count_d = '0;
      bad_d   = 1'b0;
      over_d  = 1'b0;
    end else if (accept) begin
      if (count_q == COUNT_MAX) begin
        over_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
      if (in_data_i.non_finite) bad_d = 1'b1;
    end
  end

  // Stage one: captured sample.
  logic                          p1_valid_q;
  logic signed [SAMPLE_BITS-1:0] p1_sample_q;
  logic                          p1_peak_en_q, p1_sum_en_q;

  // Stage two: magnitude and its square.
  logic                          p2_valid_q;
  logic signed [SAMPLE_BITS-1:0] p2_sample_q;
  logic [SAMPLE_BITS-1:0]        p2_mag_q;
  logic [2*SAMPLE_BITS-1:0]      p2_sq_q;
  logic                          p2_peak_en_q, p2_sum_en_q;

  logic [SAMPLE_BITS-1:0] p1_mag;
  assign p1_mag = p1_sample_q[SAMPLE_BITS-1] ? (~p1_sample_q + 1'b1) : p1_sample_q;

  // Accumulators.
  logic [SAMPLE_BITS-1:0] peak_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SQ_W-1:0]        sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      bad_q      <= 1'b0;
      over_q     <= 1'b0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      peak_q     <= '0;
      sum_q      <= '0;
      sq_q       <= '0;
    end else begin
      count_q    <= count_d;
      bad_q      <= bad_d;
      over_q     <= over_d;
      p1_valid_q <= accept;
      p2_valid_q <= p1_valid_q;
      if (cmd_i.finish) begin
        peak_q <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
      end else if (p2_valid_q) begin
        if (p2_peak_en_q && (p2_mag_q > peak_q)) peak_q <= p2_mag_q;
        if (p2_sum_en_q) begin
          sum_q <= sum_q + SUM_W'(p2_sample_q);
          sq_q  <= sq_q + SQ_W'(p2_sq_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_sample_q  <= in_data_i.sample;
      p1_peak_en_q <= !bad_d;
      p1_sum_en_q  <= !bad_d && !over_d;
    end
    if (p1_valid_q) begin
      p2_sample_q  <= p1_sample_q;
      p2_mag_q     <= p1_mag;
      p2_sq_q      <= p1_mag * p1_mag;
      p2_peak_en_q <= p1_peak_en_q;
      p2_sum_en_q  <= p1_sum_en_q;
    end
  end

  // Restoring divider, one quotient bit a cycle; the dividend register fills with the quotient.
  logic [DIV_W-1:0] dv_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] div_sh, div_rem;
  logic             div_ge;
  logic [SUM_W-1:0] sum_mag;

  assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
  assign div_sh  = {rem_q[CNT_W-2:0], dv_q[DIV_W-1]};
  assign div_ge  = (div_sh >= count_q);
  assign div_rem = div_ge ? (div_sh - count_q) : div_sh;

  // Digit-by-digit square root, one root bit a cycle.
  logic [SQRT_W-1:0] rx_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W+1:0] rrem_q;
  logic [ROOT_W+3:0] rt_sh, rt_trial;
  logic              rt_ge;

  assign rt_sh    = {rrem_q, rx_q[SQRT_W-1 -: 2]};
  assign rt_trial = (ROOT_W + 4)'({root_q, 2'b01});
  assign rt_ge    = (rt_sh >= rt_trial);

  logic [SAMPLE_BITS-1:0] dc_q;
  logic                   out_valid_q;
  alm_out_t               out_q;
  logic                   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_sum) begin
      dv_q  <= DIV_W'(sum_mag);
      rem_q <= '0;
    end else if (cmd_i.ld_sq) begin
      dc_q  <= sum_q[SUM_W-1] ? (~dv_q[SAMPLE_BITS-1:0] + 1'b1) : dv_q[SAMPLE_BITS-1:0];
      dv_q  <= DIV_W'(sq_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dv_q  <= {dv_q[DIV_W-2:0], div_ge};
      rem_q <= div_rem;
    end
    if (cmd_i.ld_root) begin
      rx_q   <= SQRT_W'(dv_q);
      root_q <= '0;
      rrem_q <= '0;
    end else if (cmd_i.root_step) begin
      rx_q   <= rx_q << 2;
      root_q <= {root_q[ROOT_W-2:0], rt_ge};
      rrem_q <= (ROOT_W + 2)'(rt_ge ? (rt_sh - rt_trial) : rt_sh);
    end
    if (cmd_i.finish) begin
      out_q.peak_level     <= peak_q;
      out_q.dc_offset      <= (bad_q || over_q) ? '0 : dc_q;
      out_q.rms_level      <= (bad_q || over_q) ? '0 : root_q[SAMPLE_BITS-1:0];
      out_q.saw_non_finite <= bad_q;
      out_q.sample_total   <= count_q;
      out_q.too_long       <= over_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    status_o            = '0;
    status_o.last_taken = accept && in_data_i.last_sample;
    status_o.pipe_idle  = !p1_valid_q && !p2_valid_q;
    status_o.skip_math  = bad_q || over_q;
    status_o.out_free   = out_free;
  end

  // The overflow flag only rises once the count has saturated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q |-> (count_q == COUNT_MAX))
    else $error("overflow flag set with count below its maximum");

  // A result is never loaded while samples are still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!p1_valid_q && !p2_valid_q))
    else $error("result loaded before the pipeline drained");

  // The divider is only started on a clean buffer with a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_sum |-> (!bad_q && !over_q && (count_q != '0)))
    else $error("division started on a flagged or empty buffer");

  // A flagged buffer reports zero mean and zero RMS.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (bad_q || over_q)) |=>
      (out_valid_o && (out_data_o.dc_offset == '0) && (out_data_o.rms_level == '0)))
    else $error("flagged buffer reported nonzero DC or RMS");

endmodule

`default_nettype wire

// ===== dv/alm_level_monitor.sv =====
`timescale 1ns / 1ps
// Level meter monitor: predicts each buffer's levels and compares them with the block's output.
module alm_level_monitor import alm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  alm_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  alm_out_t out_data_i,
  output int       fail_count_o,
  output int       due_count_o
);

  localparam longint COUNT_CAP = longint'(1) << COUNT_BITS;

  // Running totals of the buffer in progress.
  longint   peak_run   = 0;
  longint   sum_run    = 0;
  longint   square_run = 0;
  longint   count_run  = 0;
  logic     bad_run    = 1'b0;
  logic     over_run   = 1'b0;
  alm_out_t levels_due[$];
  int       fail_tally = 0;

  task automatic clear_run();
    peak_run   = 0;
    sum_run    = 0;
    square_run = 0;
    count_run  = 0;
    bad_run    = 1'b0;
    over_run   = 1'b0;
  endtask

  function automatic longint floor_root(input longint val);
    longint root;
    longint trial;
    int     b;
    root = 0;
    for (b = 30; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= val) root = trial;
    end
    return root;
  endfunction

  task automatic accumulate_sample(input alm_in_t req);
    longint   value;
    longint   mag;
    longint   dc;
    longint   rms;
    alm_out_t lvl;
    value = longint'($signed(req.sample));
    mag   = (value < 0) ? -value : value;
    // Every request counts, but the count stops at the cap and flags the overrun.
    if (count_run >= COUNT_CAP) over_run = 1'b1;
    else count_run++;
    if (req.non_finite) bad_run = 1'b1;
    if (!bad_run) begin
      if (mag > peak_run) peak_run = mag;
      if (!over_run) begin
        sum_run    += value;
        square_run += mag * mag;
      end
    end
    if (req.last_sample) begin
      dc  = 0;
      rms = 0;
      if (!bad_run && !over_run) begin
        // Signed division truncates toward zero, as the DC offset requires.
        dc  = sum_run / count_run;
        rms = floor_root(square_run / count_run);
      end
      lvl.peak_level     = peak_run[SAMPLE_BITS-1:0];
      lvl.dc_offset      = dc[SAMPLE_BITS-1:0];
      lvl.rms_level      = rms[SAMPLE_BITS-1:0];
      lvl.saw_non_finite = bad_run;
      lvl.sample_total   = count_run[CNT_W-1:0];
      lvl.too_long       = over_run;
      levels_due.push_back(lvl);
      clear_run();
    end
  endtask

  task automatic compare_field(input string label, input longint want, input longint got);
    if (want != got) begin
      fail_tally++;
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch
    alm_out_t want_lvl;
    if (!rst_ni) begin
      clear_run();
      levels_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) accumulate_sample(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (levels_due.size() == 0) begin
          fail_tally++;
          $display("%0t: result expected none, got peak %0d dc %0d rms %0d total %0d",
                   $time, out_data_i.peak_level, $signed(out_data_i.dc_offset),
                   out_data_i.rms_level, out_data_i.sample_total);
        end else begin
          want_lvl = levels_due.pop_front();
          compare_field("peak_level", longint'(want_lvl.peak_level),
                        longint'(out_data_i.peak_level));
          compare_field("dc_offset", longint'($signed(want_lvl.dc_offset)),
                        longint'($signed(out_data_i.dc_offset)));
          compare_field("rms_level", longint'(want_lvl.rms_level),
                        longint'(out_data_i.rms_level));
          compare_field("saw_non_finite", longint'(want_lvl.saw_non_finite),
                        longint'(out_data_i.saw_non_finite));
          compare_field("sample_total", longint'(want_lvl.sample_total),
                        longint'(out_data_i.sample_total));
          compare_field("too_long", longint'(want_lvl.too_long),
                        longint'(out_data_i.too_long));
        end
      end
    end
    fail_count_o <= fail_tally;
    due_count_o  <= levels_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: feeds sample buffers into the level meter, paces the result side, gives the verdict.
module tb_top;
  import alm_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = ~FULL_NEG;
  localparam int LONG_BUF     = 1 << COUNT_BITS;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1350;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  alm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  alm_out_t out_data;
  int       fail_count;
  int       due_count;
  // While quiet is set neither side inserts idle cycles.
  logic     quiet        = 1'b0;
  int       hold_asks    = 0;
  int       holds_served = 0;

  audio_level_meter_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  alm_level_monitor mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return FULL_NEG;
      1:       return FULL_POS;
      2:       return SAMPLE_BITS'(int'($urandom_range(0, 32)) - 16);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic int pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 8);
    if (roll < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic nf,
                              input logic fin);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data.sample      <= smp;
    in_data.non_finite  <= nf;
    in_data.last_sample <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_buffer(input int len, input int bad_at, input logic use_floor);
    int                            k;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          nf;
    for (k = 0; k < len; k++) begin
      smp = use_floor ? FULL_NEG : pick_sample();
      // Short buffers also pick up a stray non-finite mark now and then.
      nf = (k == bad_at) || (len < LONG_BUF && $urandom_range(0, 199) == 0);
      offer_sample(smp, nf, k == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  initial begin : result_side
    int len;
    @(posedge clk);
    forever begin
      if (hold_asks != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet || $urandom_range(0, 99) < 55) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int len;
    int spot;
    int bufs;
    int items_sent;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_sample(FULL_POS, 1'b0, 1'b1);
    offer_sample(FULL_NEG, 1'b0, 1'b1);
    offer_sample('0, 1'b0, 1'b1);
    // A mean of -1/3 truncates to zero, and -8/3 to -2.
    offer_sample(-1, 1'b0, 1'b0);
    offer_sample(1, 1'b0, 1'b0);
    offer_sample(-1, 1'b0, 1'b1);
    offer_sample(-3, 1'b0, 1'b0);
    offer_sample(-3, 1'b0, 1'b0);
    offer_sample(-2, 1'b0, 1'b1);
    // After a non-finite request the peak holds even for a full-scale sample.
    offer_sample(1000, 1'b0, 1'b0);
    offer_sample(5000000, 1'b1, 1'b0);
    offer_sample(FULL_NEG, 1'b0, 1'b1);
    offer_sample(FULL_NEG, 1'b1, 1'b1);
    offer_sample(7, 1'b1, 1'b0);
    offer_sample(FULL_POS, 1'b0, 1'b1);
    offer_sample(FULL_POS, 1'b0, 1'b0);
    offer_sample(FULL_NEG, 1'b0, 1'b1);
    wait_drained();

    // Buffers at the count cap: exactly full at negative full scale, one past it,
    // and two past it with a non-finite request somewhere inside.
    quiet = 1'b1;
    send_buffer(LONG_BUF, -1, 1'b1);
    send_buffer(LONG_BUF + 1, -1, 1'b0);
    send_buffer(LONG_BUF + 2, $urandom_range(0, LONG_BUF + 1), 1'b0);
    quiet = 1'b0;
    wait_drained();

    bufs       = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      len = pick_length();
      // Short buffers during the result hold-off fill the block until it stalls.
      if (bufs == 20) hold_asks++;
      if (bufs >= 20 && bufs < 26) len = $urandom_range(1, 3);
      quiet = (bufs >= 40 && bufs < 55);
      spot  = ($urandom_range(0, 99) < 15) ? $urandom_range(0, len - 1) : -1;
      send_buffer(len, spot, 1'b0);
      items_sent += len;
      bufs++;
      if (bufs % 25 == 0) wait_drained();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
